// ===== src/apu_pkg.sv =====
// ----------------------------------------------------------------------------
// apu_pkg
// Types, register numbers and period tables of the audio processing unit.
// ----------------------------------------------------------------------------
package apu_pkg;

  localparam int REG_COUNT_DEF = 24;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_FETCH = 2'd3;

  localparam logic [4:0] REG_TRI_LINEAR = 5'h08;
  localparam logic [4:0] REG_TRI_LO     = 5'h0A;
  localparam logic [4:0] REG_TRI_HI     = 5'h0B;
  localparam logic [4:0] REG_NOISE_ENV  = 5'h0C;
  localparam logic [4:0] REG_NOISE_PER  = 5'h0E;
  localparam logic [4:0] REG_NOISE_LEN  = 5'h0F;
  localparam logic [4:0] REG_DMC_CTRL   = 5'h10;
  localparam logic [4:0] REG_DMC_LOAD   = 5'h11;
  localparam logic [4:0] REG_DMC_ADDR   = 5'h12;
  localparam logic [4:0] REG_DMC_LEN    = 5'h13;
  localparam logic [4:0] REG_STATUS     = 5'h15;
  localparam logic [4:0] REG_FRAME      = 5'h17;

  localparam logic [10:0] PERIOD_MAX   = 11'h7FF;
  localparam logic [15:0] DMC_BASE     = 16'hC000;
  localparam logic [13:0] SEQ_LOAD_NTSC = 14'd7459;
  localparam logic [13:0] SEQ_LOAD_PAL  = 14'd8315;
  localparam logic [6:0]  DMC_VOL_TOP  = 7'd125;

  localparam logic [7:0] LEN_TAB [32] = '{
    8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};

  localparam logic [7:0] DUTY_TAB [4] = '{8'b0000_0010, 8'b0000_0110,
                                          8'b0001_1110, 8'b1111_1001};

  localparam logic [11:0] NOISE_TAB [2][16] = '{
    '{12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
      12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068},
    '{12'd4, 12'd8, 12'd14, 12'd30, 12'd60, 12'd88, 12'd118, 12'd148,
      12'd188, 12'd236, 12'd354, 12'd472, 12'd708, 12'd944, 12'd1890, 12'd3778}};

  localparam logic [8:0] DMC_TAB [2][16] = '{
    '{9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
      9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84, 9'd72, 9'd54},
    '{9'd398, 9'd354, 9'd316, 9'd298, 9'd276, 9'd236, 9'd210, 9'd198,
      9'd176, 9'd148, 9'd132, 9'd118, 9'd98, 9'd78, 9'd66, 9'd50}};

  localparam logic [13:0] FRAME4_TAB [2][8] = '{
    '{14'd7456, 14'd7458, 14'd7457, 14'd1, 14'd1, 14'd7457, 14'd1, 14'd1},
    '{14'd8314, 14'd8312, 14'd8313, 14'd1, 14'd1, 14'd8313, 14'd1, 14'd1}};

  localparam logic [13:0] FRAME5_TAB [2][8] = '{
    '{14'd1, 14'd7457, 14'd7456, 14'd7458, 14'd7458, 14'd7452, 14'd1, 14'd1},
    '{14'd1, 14'd8313, 14'd8314, 14'd8312, 14'd8314, 14'd8312, 14'd1, 14'd1}};

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] reg_index;
    logic [7:0] write_data;
    logic       odd_cycle;
    logic       fetch_busy;
  } apu_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        sample_valid;
    logic [3:0]  pulse_one_level;
    logic [3:0]  pulse_two_level;
    logic [3:0]  triangle_level;
    logic [3:0]  noise_level;
    logic [6:0]  delta_level;
    logic        frame_irq;
    logic        sample_irq;
    logic        fetch_request;
    logic [15:0] fetch_address;
  } apu_out_t;

  typedef struct packed {
    logic [3:0] setting;
    logic       is_const;
    logic       restart;
    logic [3:0] count;
    logic [3:0] level;
  } apu_env_t;

  typedef struct packed {
    logic [10:0] period;
    logic [11:0] timer;
    logic [2:0]  step;
    logic [1:0]  duty;
    logic        sw_on;
    logic [2:0]  sw_amount;
    logic [2:0]  sw_rate;
    logic        sw_down;
    logic [2:0]  sw_count;
    logic        sw_mute;
  } apu_pulse_t;

  typedef struct packed {
    apu_pulse_t [1:0] pulse;
    logic [3:0][7:0]  len;
    logic [4:0]       halt;
    apu_env_t [2:0]   env;
    logic [10:0]      tri_period;
    logic [10:0]      tri_timer;
    logic [4:0]       tri_step;
    logic [6:0]       lin_reload_val;
    logic [6:0]       lin_count;
    logic             lin_reload;
    logic [11:0]      noise_period;
    logic [11:0]      noise_timer;
    logic [14:0]      noise_shift;
    logic             noise_mode;
    logic [8:0]       dmc_period;
    logic [8:0]       dmc_timer;
    logic [6:0]       dmc_volume;
    logic [7:0]       dmc_shifter;
    logic [7:0]       dmc_fetched;
    logic [2:0]       dmc_bits;
    logic             dmc_play;
    logic             dmc_ready;
    logic             dmc_irq_en;
    logic [15:0]      dmc_start_addr;
    logic [11:0]      dmc_start_len;
    logic [15:0]      dmc_cur_addr;
    logic [11:0]      dmc_cur_len;
    logic [13:0]      seq_counter;
    logic [2:0]       seq_step;
    logic             five_step;
    logic [1:0]       pending;
    logic             firq_en;
    logic             firq_flag;
    logic             firq_line;
    logic             dmc_irq;
    logic [2:0]       phase;
    logic [3:0][3:0]  held;
  } apu_state_t;

endpackage

// ===== src/audio_processing_unit.sv =====
// ----------------------------------------------------------------------------
// audio_processing_unit
// Pulse, triangle, noise and delta sample sound generator behind byte registers.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready/in_data: a tick, a register write, a
// register read or a fetched sample byte. Each request gives exactly one
// result on out_valid/out_ready/out_data, held in an output register from the
// cycle after the request is taken. A tick is expected every processor cycle;
// the block takes one request per cycle unless a result waits on out_ready,
// all state being updated in the same edge that captures the result. Every
// eighth tick refreshes the held levels and sets sample_valid; fetch_request
// asks memory for the next delta byte, which comes back as a fetched sample
// byte request. cfg_we writes the region bit (0 NTSC, 1 PAL) with no wait.
// Reset (rst_n low, synchronous) returns all channels, the sequencer, the
// register file and the region to their power-up values and empties the
// output register. While out_ready is low a pending result holds and
// in_ready drops, so no request is taken until the result is delivered.
// ----------------------------------------------------------------------------
module audio_processing_unit
  import apu_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  apu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output apu_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  localparam int RIDX_W = $clog2(REG_COUNT);

  apu_state_t state_r, state_nxt;
  apu_out_t   out_data_r, out_nxt;
  logic       out_valid_r;
  logic       region_r;
  logic [7:0] regfile_r [REG_COUNT];

  logic       accept;
  logic       idx_ok;
  logic       do_a, do_b;
  logic [7:0] en;
  logic [7:0] d;

  function automatic apu_state_t reset_state();
    apu_state_t s;
    begin
      s = '0;
      s.pulse[1].duty = 2'd1;
      s.noise_period  = NOISE_TAB[0][0] - 12'd1;
      s.noise_shift   = 15'd1;
      s.dmc_period    = DMC_TAB[0][0] - 9'd1;
      s.seq_counter   = SEQ_LOAD_NTSC;
      s.seq_step      = 3'd5;
      s.firq_en       = 1'b1;
      return s;
    end
  endfunction

  function automatic apu_pulse_t sweep_apply(apu_pulse_t x, logic extra);
    logic [15:0] p;
    begin
      p = {5'd0, x.period};
      if (x.sw_amount != 3'd0) begin
        if (x.sw_down) p = p - (p >> x.sw_amount) - {15'd0, extra};
        else p = p + (p >> x.sw_amount);
      end
      if (p > 16'd8 && p < {5'd0, PERIOD_MAX}) begin
        x.sw_mute = 1'b0;
        if (x.sw_on && x.sw_amount != 3'd0) x.period = p[10:0];
      end else begin
        x.sw_mute = 1'b1;
      end
      return x;
    end
  endfunction

  function automatic apu_pulse_t sweep_clock(apu_pulse_t x, logic extra);
    begin
      if (x.sw_count == 3'd0) begin
        x = sweep_apply(x, extra);
        x.sw_count = x.sw_rate;
      end else begin
        x.sw_count = x.sw_count - 3'd1;
      end
      return x;
    end
  endfunction

  function automatic apu_env_t env_clock(apu_env_t e, logic loop_en);
    begin
      if (e.restart) begin
        e.restart = 1'b0;
        e.count = e.setting;
        e.level = 4'd15;
      end else if (e.count == 4'd0) begin
        e.count = e.setting;
        if (e.level == 4'd0) begin
          if (loop_en) e.level = 4'd15;
        end else begin
          e.level = e.level - 4'd1;
        end
      end else begin
        e.count = e.count - 4'd1;
      end
      return e;
    end
  endfunction

  function automatic logic [3:0] env_out(apu_env_t e);
    return e.is_const ? e.setting : e.level;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_ok    = 32'(in_data.reg_index) < REG_COUNT;
  assign en        = regfile_r[REG_STATUS[RIDX_W-1:0]];
  assign d         = in_data.write_data;

  always_comb begin
    state_nxt = state_r;
    out_nxt   = '0;
    do_a      = 1'b0;
    do_b      = 1'b0;

    case (in_data.cmd)
      CMD_TICK: begin
        // level sampling
        if (state_r.phase == 3'd0) begin
          out_nxt.sample_valid = 1'b1;
          for (int c = 0; c < 2; c++) begin
            if (state_r.len[c] != 8'd0 && en[c] && !state_r.pulse[c].sw_mute &&
                state_r.pulse[c].period >= 11'd8 && state_r.pulse[c].period < PERIOD_MAX)
            begin
              state_nxt.held[c] =
                DUTY_TAB[state_r.pulse[c].duty][state_r.pulse[c].step] ?
                env_out(state_r.env[c]) : 4'd0;
            end
          end
          if (state_r.len[2] != 8'd0 && state_r.lin_count != 7'd0 && en[2] &&
              state_r.tri_period >= 11'd2) begin
            state_nxt.held[2] = state_r.tri_step[4] ? state_r.tri_step[3:0]
                                                    : ~state_r.tri_step[3:0];
          end
          if (state_r.len[3] != 8'd0 && en[3] && state_r.noise_period != 12'd0) begin
            state_nxt.held[3] = state_r.noise_shift[0] ? 4'd0 : env_out(state_r.env[2]);
          end
        end
        state_nxt.phase = state_r.phase + 3'd1;

        // channel timers
        for (int c = 0; c < 2; c++) begin
          if (state_r.pulse[c].timer == 12'd0) begin
            state_nxt.pulse[c].timer = {state_r.pulse[c].period, 1'b1};
            state_nxt.pulse[c].step  = state_r.pulse[c].step + 3'd1;
          end else begin
            state_nxt.pulse[c].timer = state_r.pulse[c].timer - 12'd1;
          end
        end
        if (state_r.tri_timer == 11'd0) begin
          state_nxt.tri_timer = state_r.tri_period;
          state_nxt.tri_step  = state_r.tri_step + 5'd1;
        end else begin
          state_nxt.tri_timer = state_r.tri_timer - 11'd1;
        end
        if (state_r.noise_timer == 12'd0) begin
          state_nxt.noise_timer = state_r.noise_period;
          state_nxt.noise_shift = {state_r.noise_shift[0] ^
                                   (state_r.noise_mode ? state_r.noise_shift[6]
                                                       : state_r.noise_shift[1]),
                                   state_r.noise_shift[14:1]};
        end else begin
          state_nxt.noise_timer = state_r.noise_timer - 12'd1;
        end

        // delta output unit
        if (state_r.dmc_timer == 9'd0) begin
          state_nxt.dmc_timer = state_r.dmc_period;
          if (state_r.dmc_play) begin
            if (state_r.dmc_shifter[0]) begin
              if (state_r.dmc_volume <= DMC_VOL_TOP)
                state_nxt.dmc_volume = state_r.dmc_volume + 7'd2;
            end else if (state_r.dmc_volume >= 7'd2) begin
              state_nxt.dmc_volume = state_r.dmc_volume - 7'd2;
            end
            state_nxt.dmc_shifter = {1'b0, state_r.dmc_shifter[7:1]};
          end
          if (state_r.dmc_bits == 3'd0) begin
            if (state_r.dmc_ready) begin
              state_nxt.dmc_shifter = state_r.dmc_fetched;
              state_nxt.dmc_play    = 1'b1;
              state_nxt.dmc_ready   = 1'b0;
            end else begin
              state_nxt.dmc_play = 1'b0;
            end
            state_nxt.dmc_bits = 3'd7;
          end else begin
            state_nxt.dmc_bits = state_r.dmc_bits - 3'd1;
          end
        end else begin
          state_nxt.dmc_timer = state_r.dmc_timer - 9'd1;
        end

        if (!state_nxt.dmc_ready && !in_data.fetch_busy && state_r.dmc_cur_len != 12'd0)
        begin
          out_nxt.fetch_request = 1'b1;
          out_nxt.fetch_address = state_r.dmc_cur_addr;
          state_nxt.dmc_cur_len = state_r.dmc_cur_len - 12'd1;
        end

        // frame sequencer
        if (state_r.pending[0] && in_data.odd_cycle) begin
          state_nxt.five_step = state_r.pending[1];
          state_nxt.pending   = 2'd0;
          state_nxt.seq_step  = 3'd5;
          state_nxt.seq_counter = state_r.pending[1] ? 14'd1 :
                                  (region_r ? SEQ_LOAD_PAL : SEQ_LOAD_NTSC);
        end
        if (state_nxt.seq_counter != 14'd0) begin
          state_nxt.seq_counter = state_nxt.seq_counter - 14'd1;
        end else begin
          state_nxt.seq_step = (state_nxt.seq_step >= 3'd5) ? 3'd0
                                                            : state_nxt.seq_step + 3'd1;
          if (!state_nxt.five_step) begin
            state_nxt.seq_counter = FRAME4_TAB[region_r][state_nxt.seq_step] - 14'd1;
            if (state_nxt.seq_step == 3'd3 || state_nxt.seq_step == 3'd5) begin
              if (state_nxt.firq_en) state_nxt.firq_flag = 1'b1;
            end else begin
              do_a = state_nxt.seq_step == 3'd1 || state_nxt.seq_step == 3'd4;
              do_b = 1'b1;
              if (state_nxt.seq_step == 3'd4 && state_nxt.firq_en) begin
                state_nxt.firq_flag = 1'b1;
                state_nxt.firq_line = 1'b1;
              end
            end
          end else begin
            state_nxt.seq_counter = FRAME5_TAB[region_r][state_nxt.seq_step] - 14'd1;
            if (state_nxt.seq_step != 3'd1 && state_nxt.seq_step != 3'd5) begin
              do_a = state_nxt.seq_step == 3'd0 || state_nxt.seq_step == 3'd3;
              do_b = 1'b1;
            end
          end
        end

        // length and sweep
        if (do_a) begin
          for (int c = 0; c < 2; c++) begin
            if (state_nxt.len[c] != 8'd0) begin
              state_nxt.pulse[c] = sweep_clock(state_nxt.pulse[c], c == 0);
              if (!state_nxt.halt[c]) state_nxt.len[c] = state_nxt.len[c] - 8'd1;
            end
          end
          for (int c = 2; c < 4; c++) begin
            if (state_nxt.len[c] != 8'd0 && !state_nxt.halt[c])
              state_nxt.len[c] = state_nxt.len[c] - 8'd1;
          end
        end
        // envelopes and linear counter
        if (do_b) begin
          if (state_nxt.len[0] != 8'd0)
            state_nxt.env[0] = env_clock(state_nxt.env[0], state_nxt.halt[0]);
          if (state_nxt.len[1] != 8'd0)
            state_nxt.env[1] = env_clock(state_nxt.env[1], state_nxt.halt[1]);
          if (state_nxt.len[3] != 8'd0)
            state_nxt.env[2] = env_clock(state_nxt.env[2], state_nxt.halt[3]);
          if (state_nxt.lin_reload) state_nxt.lin_count = state_nxt.lin_reload_val;
          else if (state_nxt.lin_count != 7'd0)
            state_nxt.lin_count = state_nxt.lin_count - 7'd1;
          if (!state_nxt.halt[2]) state_nxt.lin_reload = 1'b0;
        end
      end

      CMD_WRITE: begin
        if (idx_ok) begin
          for (int c = 0; c < 2; c++) begin
            if (in_data.reg_index[4:3] == 2'b00 && in_data.reg_index[2] == c[0]) begin
              case (in_data.reg_index[1:0])
                2'd0: begin
                  state_nxt.env[c].setting  = d[3:0];
                  state_nxt.pulse[c].duty   = d[7:6];
                  state_nxt.env[c].is_const = d[4];
                  state_nxt.halt[c]         = d[5];
                end
                2'd1: begin
                  state_nxt.pulse[c].sw_on     = d[7];
                  state_nxt.pulse[c].sw_amount = d[2:0];
                  state_nxt.pulse[c].sw_rate   = d[6:4];
                  state_nxt.pulse[c].sw_down   = d[3];
                end
                2'd2: state_nxt.pulse[c].period[7:0] = d;
                default: begin
                  state_nxt.pulse[c].step = 3'd0;
                  if (en[c]) state_nxt.len[c] = LEN_TAB[d[7:3]];
                  state_nxt.pulse[c].period[10:8] = d[2:0];
                  state_nxt.env[c].restart = 1'b1;
                end
              endcase
              if (state_nxt.pulse[c].period > 11'd8 && state_nxt.pulse[c].period < PERIOD_MAX)
                state_nxt.pulse[c].sw_mute = 1'b0;
              if (in_data.reg_index[1:0] == 2'd1) begin
                state_nxt.pulse[c].sw_count = d[6:4];
                if (state_r.pulse[c].sw_count == 3'd0)
                  state_nxt.pulse[c] = sweep_apply(state_nxt.pulse[c], c == 0);
              end
            end
          end
          case (in_data.reg_index)
            REG_TRI_LINEAR: begin
              state_nxt.lin_reload_val = d[6:0];
              state_nxt.halt[2] = d[7];
            end
            REG_TRI_LO: state_nxt.tri_period[7:0] = d;
            REG_TRI_HI: begin
              if (en[2]) state_nxt.len[2] = LEN_TAB[d[7:3]];
              state_nxt.tri_period[10:8] = d[2:0];
              state_nxt.lin_reload = 1'b1;
            end
            REG_NOISE_ENV: begin
              state_nxt.env[2].setting  = d[3:0];
              state_nxt.env[2].is_const = d[4];
              state_nxt.halt[3] = d[5];
            end
            REG_NOISE_PER: begin
              state_nxt.noise_mode   = d[7];
              state_nxt.noise_period = NOISE_TAB[region_r][d[3:0]] - 12'd1;
            end
            REG_NOISE_LEN: begin
              if (en[3]) state_nxt.len[3] = LEN_TAB[d[7:3]];
              state_nxt.env[2].restart = 1'b1;
            end
            REG_DMC_CTRL: begin
              state_nxt.dmc_period = DMC_TAB[region_r][d[3:0]] - 9'd1;
              state_nxt.halt[4]    = d[6];
              state_nxt.dmc_irq_en = d[7];
              if (!d[7]) state_nxt.dmc_irq = 1'b0;
            end
            REG_DMC_LOAD: state_nxt.dmc_volume = d[6:0];
            REG_DMC_ADDR: state_nxt.dmc_start_addr = DMC_BASE | {2'b00, d, 6'd0};
            REG_DMC_LEN:  state_nxt.dmc_start_len = {d, 4'd1};
            REG_STATUS: begin
              for (int c = 0; c < 4; c++) begin
                if (!d[c]) state_nxt.len[c] = 8'd0;
              end
              if (!d[4]) begin
                state_nxt.dmc_cur_len = 12'd0;
              end else if (state_r.dmc_cur_len == 12'd0) begin
                state_nxt.dmc_cur_addr = state_r.dmc_start_addr;
                state_nxt.dmc_cur_len  = state_r.dmc_start_len;
              end
              state_nxt.dmc_irq = 1'b0;
            end
            REG_FRAME: begin
              state_nxt.firq_en = !d[6];
              if (d[6]) begin
                state_nxt.firq_flag = 1'b0;
                state_nxt.firq_line = 1'b0;
              end
              state_nxt.pending = {d[7], 1'b1};
            end
            default: ;
          endcase
        end
      end

      CMD_READ: begin
        if (idx_ok) begin
          if (in_data.reg_index == REG_STATUS) begin
            out_nxt.read_data = {state_r.dmc_irq, state_r.firq_flag, 1'b0,
                                 state_r.dmc_cur_len != 12'd0,
                                 state_r.len[3] != 8'd0, state_r.len[2] != 8'd0,
                                 state_r.len[1] != 8'd0, state_r.len[0] != 8'd0};
            state_nxt.firq_flag = 1'b0;
            state_nxt.firq_line = 1'b0;
          end else begin
            out_nxt.read_data = regfile_r[in_data.reg_index[RIDX_W-1:0]];
          end
        end
      end

      default: begin
        state_nxt.dmc_ready    = 1'b1;
        state_nxt.dmc_fetched  = d;
        state_nxt.dmc_cur_addr = {1'b1, state_r.dmc_cur_addr[14:0] + 15'd1};
        if (state_r.dmc_cur_len == 12'd0) begin
          if (state_r.halt[4]) begin
            state_nxt.dmc_cur_addr = state_r.dmc_start_addr;
            state_nxt.dmc_cur_len  = state_r.dmc_start_len;
          end else if (state_r.dmc_irq_en) begin
            state_nxt.dmc_irq = 1'b1;
          end
        end
      end
    endcase

    out_nxt.pulse_one_level = state_nxt.held[0];
    out_nxt.pulse_two_level = state_nxt.held[1];
    out_nxt.triangle_level  = state_nxt.held[2];
    out_nxt.noise_level     = state_nxt.held[3];
    out_nxt.delta_level     = (in_data.cmd == CMD_TICK) ? state_r.dmc_volume
                                                        : state_nxt.dmc_volume;
    out_nxt.frame_irq       = state_nxt.firq_line;
    out_nxt.sample_irq      = state_nxt.dmc_irq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= reset_state();
      for (int i = 0; i < REG_COUNT; i++) regfile_r[i] <= 8'd0;
      region_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (cfg_we) region_r <= cfg_wdata;
      if (accept) begin
        state_r     <= state_nxt;
        out_data_r  <= out_nxt;
        out_valid_r <= 1'b1;
        if (in_data.cmd == CMD_WRITE && idx_ok)
          regfile_r[in_data.reg_index[RIDX_W-1:0]] <= in_data.write_data;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_no_tick_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd != CMD_TICK) |=>
    (!out_data_r.sample_valid && !out_data_r.fetch_request))
    else $error("sample or fetch flag on a non-tick request");

  a_fetch_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.fetch_request) |-> (out_data_r.fetch_address == 16'd0))
    else $error("fetch address without fetch request");

  a_sample_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_TICK && state_r.phase == 3'd0) |=>
    out_data_r.sample_valid)
    else $error("level refresh missed");

endmodule
